/* src/byte_transpose_expgolomb_encoder_top_defines.svh */
// Assertion macros shared by the checker.
`ifndef BYTE_TRANSPOSE_EXPGOLOMB_ENCODER_TOP_DEFINES_SVH
`define BYTE_TRANSPOSE_EXPGOLOMB_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BTXEG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btxeg same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define BTXEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btxeg next-cycle check failed");

`endif

/* src/btxeg_pkg.sv */
package btxeg_pkg;

  localparam int LANES   = 8;
  localparam int WORD_W  = 64;
  localparam int LEN_W   = 7;   // holds 1..64
  localparam int FILL_W  = 6;   // holds 0..63
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [LANES-1:0][7:0] lanes_t;

  // Queue entry: value left-aligned, its bit length, end-of-stream mark.
  typedef struct packed {
    word_t payload;
    len_t  len;
    logic  eos;
  } q_entry_t;

  // Signed byte to unsigned: positive v -> 2v-1, else -2v, modulo 256.
  function automatic logic [7:0] zigzag(input logic [7:0] raw);
    logic [7:0] dbl;
    dbl = {raw[6:0], 1'b0};
    if (raw != 8'd0 && !raw[7]) begin
      return dbl - 8'd1;
    end else begin
      return 8'd0 - dbl;
    end
  endfunction

  // 8x8 bit matrix transpose: bit b of lane j moves to bit 8b+j.
  function automatic word_t transpose(input word_t x);
    word_t r;
    for (int b = 0; b < LANES; b++) begin
      for (int j = 0; j < LANES; j++) begin
        r[8*b+j] = x[8*j+b];
      end
    end
    return r;
  endfunction

  // Bit length of a non-zero word, two-level leading-one search.
  function automatic len_t bit_length(input word_t m);
    logic [7:0] nz;
    logic [2:0] hi_byte;
    logic [7:0] sel;
    logic [2:0] hi_bit;
    for (int i = 0; i < LANES; i++) begin
      nz[i] = |m[8*i +: 8];
    end
    hi_byte = 3'd0;
    for (int i = 0; i < LANES; i++) begin
      if (nz[i]) begin
        hi_byte = 3'(i);
      end
    end
    sel = m[8*hi_byte +: 8];
    hi_bit = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (sel[i]) begin
        hi_bit = 3'(i);
      end
    end
    return {1'b0, hi_byte, hi_bit} + len_t'(1);
  endfunction

endpackage

/* src/byte_transpose_expgolomb_encoder_top.sv */
// Throughput: one input beat per cycle into the front while the queue has room; the packer
//   takes one step per output word an item completes, plus one if its last step fills no word.
// The packer, with its single 64-bit output word register, sets the sustained rate.
// Reset: synchronous, active high; clears all valids, queue pointers and the partial word.
module byte_transpose_expgolomb_encoder_top (
  input  logic                    clk,
  input  logic                    rst,
  // sample channel
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic signed [7:0]       sample0,
  input  logic signed [7:0]       sample1,
  input  logic signed [7:0]       sample2,
  input  logic signed [7:0]       sample3,
  input  logic signed [7:0]       sample4,
  input  logic signed [7:0]       sample5,
  input  logic signed [7:0]       sample6,
  input  logic signed [7:0]       sample7,
  input  logic                    end_of_stream,
  // word channel
  output logic                    word_valid,
  input  logic                    word_ready,
  output logic [63:0]             code_word,
  output logic                    final_word
);

  // Front: two stages. Stage 1 zigzags the lanes, transposes the 8x8 bit
  // matrix and adds one; stage 2 finds the bit length n. The entry is
  // pushed with the value shifted up so its top set bit sits at the MSB.
  // The queue (four entries) decouples the front from the packer.
  // Back: each step the packer places into the partial word first any
  // remaining prefix zeros (n-1 of them) and then as many value bits as fit;
  // a step that fills the word, or ends an end-of-stream item, loads the
  // output register. The output register lets the packer run while a
  // finished word waits for the sink.

  btxeg_pkg::lanes_t   lanes;
  logic                push_valid;
  logic                push_ready;
  btxeg_pkg::q_entry_t push_data;
  logic                head_valid;
  logic                pop;
  btxeg_pkg::q_entry_t head_data;

  assign lanes[0] = sample0;
  assign lanes[1] = sample1;
  assign lanes[2] = sample2;
  assign lanes[3] = sample3;
  assign lanes[4] = sample4;
  assign lanes[5] = sample5;
  assign lanes[6] = sample6;
  assign lanes[7] = sample7;

  btxeg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample_valid),
    .in_ready   (sample_ready),
    .lanes      (lanes),
    .eos        (end_of_stream),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  btxeg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  // packer and output word register
  btxeg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .code_word  (code_word),
    .final_word (final_word)
  );

endmodule

/* src/btxeg_front.sv */
module btxeg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  btxeg_pkg::lanes_t   lanes,
  input  logic                eos,
  output logic                push_valid,
  input  logic                push_ready,
  output btxeg_pkg::q_entry_t push_data
);

  localparam btxeg_pkg::len_t WordLen = btxeg_pkg::len_t'(btxeg_pkg::WORD_W);

  btxeg_pkg::word_t packed_w;
  btxeg_pkg::word_t m_calc;

  logic             v1;
  btxeg_pkg::word_t m1;
  logic             eos1;
  logic             v2;
  btxeg_pkg::word_t m2;
  btxeg_pkg::len_t  n2;
  logic             eos2;

  logic adv1, adv2, s1_free, s2_free;

  // stage 1: zigzag, transpose, +1
  always_comb begin
    for (int j = 0; j < btxeg_pkg::LANES; j++) begin
      packed_w[8*j +: 8] = btxeg_pkg::zigzag(lanes[j]);
    end
    m_calc = btxeg_pkg::transpose(packed_w) + btxeg_pkg::word_t'(1);
  end

  assign adv2     = v2 && push_ready;
  assign s2_free  = !v2 || adv2;
  assign adv1     = v1 && s2_free;
  assign s1_free  = !v1 || adv1;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s1_free) begin
        v1 <= in_valid;
      end
      if (s2_free) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      m1   <= m_calc;
      eos1 <= eos;
    end
    // stage 2: leading-one search
    if (adv1) begin
      m2   <= m1;
      n2   <= btxeg_pkg::bit_length(m1);
      eos2 <= eos1;
    end
  end

  // normalise: top significant bit to the MSB
  assign push_valid        = v2;
  assign push_data.payload = m2 << (WordLen - n2);
  assign push_data.len     = n2;
  assign push_data.eos     = eos2;

endmodule

/* src/btxeg_queue.sv */
module btxeg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  btxeg_pkg::q_entry_t push_data,
  output logic                head_valid,
  input  logic                pop,
  output btxeg_pkg::q_entry_t head_data
);

  localparam logic [btxeg_pkg::Q_CNT_W-1:0] Full =
    btxeg_pkg::Q_CNT_W'(btxeg_pkg::Q_DEPTH);
  localparam logic [btxeg_pkg::Q_PTR_W-1:0] PtrStep = btxeg_pkg::Q_PTR_W'(1);
  localparam logic [btxeg_pkg::Q_CNT_W-1:0] CntStep = btxeg_pkg::Q_CNT_W'(1);

  btxeg_pkg::q_entry_t             mem [btxeg_pkg::Q_DEPTH];
  logic [btxeg_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [btxeg_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [btxeg_pkg::Q_CNT_W-1:0]   count;
  logic                            do_push, do_pop;

  assign push_ready = (count != Full);
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PtrStep;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrStep;
      end
      if (do_push && !do_pop) begin
        count <= count + CntStep;
      end else if (do_pop && !do_push) begin
        count <= count - CntStep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/btxeg_back.sv */
module btxeg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  btxeg_pkg::q_entry_t head_data,
  output logic                pop,
  output logic                word_valid,
  input  logic                word_ready,
  output btxeg_pkg::word_t    code_word,
  output logic                final_word
);

  localparam btxeg_pkg::len_t WordLen = btxeg_pkg::len_t'(btxeg_pkg::WORD_W);

  // entry in progress
  logic              busy;
  btxeg_pkg::fill_t  rem_zero;
  btxeg_pkg::len_t   rem_pay;
  btxeg_pkg::word_t  payload;
  logic              eos_cur;
  // partly filled output word
  btxeg_pkg::word_t  pending;
  btxeg_pkg::fill_t  fill;

  btxeg_pkg::fill_t  cur_zero;
  btxeg_pkg::len_t   cur_pay;
  btxeg_pkg::word_t  cur_ma;
  logic              cur_eos;
  logic              have;
  btxeg_pkg::len_t   space, f1, space2, take, total;
  btxeg_pkg::word_t  merged;
  logic              zero_only, done, emit, last;
  btxeg_pkg::word_t  word;
  btxeg_pkg::fill_t  zero_next, fill_next;
  btxeg_pkg::len_t   pay_next;
  btxeg_pkg::word_t  ma_next, pending_next;
  logic              out_ok, step;

  always_comb begin
    cur_zero = busy ? rem_zero : btxeg_pkg::fill_t'(head_data.len - btxeg_pkg::len_t'(1));
    cur_pay  = busy ? rem_pay : head_data.len;
    cur_ma   = busy ? payload : head_data.payload;
    cur_eos  = busy ? eos_cur : head_data.eos;
    have     = busy || head_valid;

    space     = WordLen - {1'b0, fill};
    zero_only = ({1'b0, cur_zero} >= space);
    f1        = {1'b0, fill} + {1'b0, cur_zero};
    space2    = WordLen - f1;
    take      = (cur_pay < space2) ? cur_pay : space2;
    total     = f1 + take;
    merged    = pending | (cur_ma >> f1[btxeg_pkg::FILL_W-1:0]);

    if (zero_only) begin
      // prefix zeros alone fill the word
      done         = 1'b0;
      emit         = 1'b1;
      last         = 1'b0;
      word         = pending;
      zero_next    = btxeg_pkg::fill_t'({1'b0, cur_zero} - space);
      pay_next     = cur_pay;
      ma_next      = cur_ma;
      pending_next = '0;
      fill_next    = '0;
    end else begin
      done         = (cur_pay == take);
      last         = done && cur_eos;
      emit         = (total == WordLen) || last;
      word         = merged;
      zero_next    = '0;
      pay_next     = cur_pay - take;
      ma_next      = cur_ma << take;
      pending_next = emit ? '0 : merged;
      fill_next    = emit ? '0 : total[btxeg_pkg::FILL_W-1:0];
    end

    out_ok = !word_valid || word_ready;
    step   = have && (!emit || out_ok);
    pop    = step && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      word_valid <= 1'b0;
      pending    <= '0;
      fill       <= '0;
    end else begin
      if (step) begin
        busy    <= !done;
        pending <= pending_next;
        fill    <= fill_next;
      end
      if (step && emit) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rem_zero <= zero_next;
      rem_pay  <= pay_next;
      payload  <= ma_next;
      eos_cur  <= cur_eos;
    end
    if (step && emit) begin
      code_word  <= word;
      final_word <= last;
    end
  end

endmodule

/* src/btxeg_checker.sv */
`include "byte_transpose_expgolomb_encoder_top_defines.svh"

module btxeg_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        word_valid,
  input logic        word_ready,
  input logic [63:0] code_word,
  input logic        final_word
);

  logic        word_stall;
  logic [64:0] word_beat;

  assign word_stall = word_valid && !word_ready;
  assign word_beat  = {code_word, final_word};

  // a stalled word beat holds
  `BTXEG_ASSERT_NEXT(a_word_hold, clk, rst, word_stall, word_valid && $stable(word_beat))

  // no word can appear straight after reset
  `BTXEG_ASSERT_SAME(a_quiet_after_rst, clk, rst, $past(rst) || $past(rst, 2), !word_valid)

  // front is empty and ready straight after reset
  `BTXEG_ASSERT_SAME(a_ready_after_rst, clk, rst, $past(rst), sample_ready)

  // a beat offered right after reset is taken
  `BTXEG_ASSERT_SAME(a_take_after_rst, clk, rst, $past(rst) && sample_valid, sample_ready)

endmodule

bind byte_transpose_expgolomb_encoder_top btxeg_checker u_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

// One packed output word together with its end-of-stream flag.
typedef struct {
  logic [63:0] bits;
  logic        last;
} packed_word_t;

// Bit-exact prediction of the encoder: zigzag map, 8x8 transpose, order-0
// exp-Golomb codeword packed MSB first into 64-bit words.
class golomb_stream_model;
  logic [63:0]  partial;
  int unsigned  filled;
  int unsigned  mismatches;
  packed_word_t awaited[$];
  int unsigned  fresh;

  function new();
    partial    = '0;
    filled     = 0;
    mismatches = 0;
  endfunction

  // Appends a predicted word at the tail of the queue.
  function void note_word(input packed_word_t w);
    awaited = {awaited, w};
  endfunction

  function void push_bit(input logic b);
    partial[63 - filled] = b;
    filled++;
    if (filled == 64) begin
      note_word(packed_word_t'{partial, 1'b0});
      fresh++;
      partial = '0;
      filled  = 0;
    end
  endfunction

  // Lane j sits at bits 8j..8j+7 of lanes.
  function void absorb_batch(input logic [63:0] lanes, input logic eos);
    logic [63:0]  mapped;
    logic [63:0]  flipped;
    logic [64:0]  plus_one;
    packed_word_t tail;
    int           v;
    int           len;
    mapped = '0;
    fresh  = 0;
    for (int j = 0; j < 8; j++) begin
      v = int'($signed(lanes[8*j +: 8]));
      mapped[8*j +: 8] = (v > 0) ? 8'(2 * v - 1) : 8'(-2 * v);
    end
    for (int b = 0; b < 8; b++) begin
      for (int j = 0; j < 8; j++) begin
        flipped[8*b + j] = mapped[8*j + b];
      end
    end
    // 65 bits so that an all-ones word would still code correctly
    plus_one = {1'b0, flipped} + 65'd1;
    len = 0;
    for (int i = 0; i < 65; i++) begin
      if (plus_one[i]) len = i + 1;
    end
    for (int i = 1; i < len; i++) push_bit(1'b0);
    for (int i = len - 1; i >= 0; i--) push_bit(plus_one[i]);
    if (eos) begin
      if (filled != 0) begin
        note_word(packed_word_t'{partial, 1'b1});
      end else if (fresh > 0) begin
        tail = awaited.pop_back();
        tail.last = 1'b1;
        note_word(tail);
      end
      partial = '0;
      filled  = 0;
    end
  endfunction

  function void compare_word(input logic [63:0] bits, input logic last);
    packed_word_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word: expected none, actual %h final %b", $time, bits, last);
      return;
    end
    want = awaited.pop_front();
    if (bits !== want.bits) begin
      mismatches++;
      $display("%0t: code_word: expected %h, actual %h", $time, want.bits, bits);
    end
    if (last !== want.last) begin
      mismatches++;
      $display("%0t: final_word: expected %b, actual %b", $time, want.last, last);
    end
  endfunction
endclass

module testbench;

  // Generous cycle budget: 333 beats in all, directed and random.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BEATS  = 320;
  localparam int DRAIN_CYCLES  = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  logic signed [7:0] sample0 = '0;
  logic signed [7:0] sample1 = '0;
  logic signed [7:0] sample2 = '0;
  logic signed [7:0] sample3 = '0;
  logic signed [7:0] sample4 = '0;
  logic signed [7:0] sample5 = '0;
  logic signed [7:0] sample6 = '0;
  logic signed [7:0] sample7 = '0;
  logic              end_of_stream = 1'b0;
  logic              word_valid;
  logic              word_ready = 1'b0;
  logic [63:0]       code_word;
  logic              final_word;

  int unsigned        cycles = 0;
  // When set, neither side idles: back-to-back beats on both channels.
  bit                 no_gaps = 1'b0;
  golomb_stream_model stream_model;

  byte_transpose_expgolomb_encoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample0      (sample0),
    .sample1      (sample1),
    .sample2      (sample2),
    .sample3      (sample3),
    .sample4      (sample4),
    .sample5      (sample5),
    .sample6      (sample6),
    .sample7      (sample7),
    .end_of_stream(end_of_stream),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .code_word    (code_word),
    .final_word   (final_word)
  );

  always #6 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Presents one batch and holds it until the beat is taken. Valid is only
  // dropped when an idle gap is drawn, so back-to-back beats keep it high.
  task automatic send_batch(input logic [63:0] lanes, input logic eos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    {sample7, sample6, sample5, sample4, sample3, sample2, sample1, sample0} <= lanes;
    end_of_stream <= eos;
    do @(posedge clk); while (!sample_ready);
    stream_model.absorb_batch(lanes, eos);
  endtask

  // Mix of lane contents: full-range noise gives long codewords, small
  // values give short ones that often complete no word at all.
  function automatic logic [63:0] random_lanes();
    logic [63:0] lanes;
    logic [7:0]  corner [6];
    int          shape;
    corner = '{8'h80, 8'h81, 8'hFF, 8'h00, 8'h01, 8'h7F};
    shape = $urandom_range(0, 9);
    lanes = '0;
    for (int j = 0; j < 8; j++) begin
      case (shape)
        5, 6:    lanes[8*j +: 8] = 8'($urandom_range(0, 6) - 3);
        7:       lanes[8*j +: 8] = corner[$urandom_range(0, 5)];
        8:       lanes[8*j +: 8] = (j == 0) ? 8'($urandom) : lanes[7:0];
        9:       lanes[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
        default: lanes[8*j +: 8] = 8'($urandom);
      endcase
    end
    return lanes;
  endfunction

  // Sink side: a fresh stall is drawn for every word.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        word_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      word_ready <= 1'b1;
      do @(posedge clk); while (!(word_valid && word_ready));
      stream_model.compare_word(code_word, final_word);
    end
  end

  initial begin
    logic eos;
    stream_model = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats
    send_batch(64'h0, 1'b0);                  // zero word: one-bit codeword
    send_batch({8{8'h7F}}, 1'b0);             // most positive lanes
    send_batch({8{8'h80}}, 1'b0);             // -128 wraps to code 0
    send_batch({8{8'h81}}, 1'b0);             // -127: longest codeword, 127 bits
    send_batch({8{8'hFF}}, 1'b0);
    send_batch({8{8'h01}}, 1'b1);             // end of stream with bits pending
    // 63 + 1 bits land exactly on a word boundary: the full word is the last
    send_batch(64'hFC00_0000_0000_0000, 1'b0);
    send_batch(64'h0, 1'b1);
    // 63 bits pending, then a 127-bit codeword and a flush: three words from one beat
    send_batch(64'hFC00_0000_0000_0000, 1'b0);
    send_batch({8{8'h81}}, 1'b1);
    send_batch({4{16'h807F}}, 1'b0);
    send_batch(64'hC040_0081_0FFF_7F80, 1'b1);
    send_batch({8{8'hFF}}, 1'b1);             // a stream of a single batch

    // Random streams; idling switched off now and then for a burst.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      eos = (i == RANDOM_BEATS - 1) || ($urandom_range(0, 7) == 0);
      send_batch(random_lanes(), eos);
    end
    sample_valid <= 1'b0;
    no_gaps = 1'b0;

    while (stream_model.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (stream_model.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
